[rtl/core/xoshiro256pp_generator_macros.svh]
// Assertion macros shared by the generator RTL.
`ifndef XOSHIRO256PP_GENERATOR_MACROS_SVH
`define XOSHIRO256PP_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define XO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/xo256pp_pkg.sv]
// Shared types, opcodes and jump polynomials for the xoshiro256++ generator.
package xo256pp_pkg;

	localparam int WORD_W     = 64;
	localparam int WORD_COUNT = 4;
	localparam int COUNT_W    = 8;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [1:0]        opcode_t;

	localparam opcode_t OP_SAMPLE    = 2'd0;
	localparam opcode_t OP_SEED      = 2'd1;
	localparam opcode_t OP_SHORT_JMP = 2'd2;
	localparam opcode_t OP_LONG_JMP  = 2'd3;

	localparam word_t SHORT_POLY [WORD_COUNT] = '{
		64'h180ec6d33cfd0aba, 64'hd5a61266f0c9392c,
		64'ha9582618e03fc9aa, 64'h39abdc4529b1661c
	};

	localparam word_t LONG_POLY [WORD_COUNT] = '{
		64'h76e15d3efefdcbbf, 64'hc5004e441c522fb3,
		64'h77710069854ee241, 64'h39109bb02acbe635
	};

	// Operation the sequencer asks of the state datapath
	typedef enum logic [2:0] {
		CORE_HOLD,
		CORE_SAMPLE,
		CORE_SEED,
		CORE_JSTART,
		CORE_JSTEP,
		CORE_JLOAD
	} core_op_t;

	typedef struct packed {
		core_op_t op;
		logic     poly_bit;
	} core_ctrl_t;

	typedef struct packed {
		word_t sample_value;
		logic  words_nz;
		logic  accum_nz;
	} core_stat_t;

	function automatic logic jump_poly_bit(input logic long_jmp,
		input logic [COUNT_W-1:0] idx);
		word_t w;
		w = long_jmp ? LONG_POLY[idx[7:6]] : SHORT_POLY[idx[7:6]];
		return w[idx[5:0]];
	endfunction

endpackage

[rtl/core/xo256pp_cmd_if.sv]
// Command channel: opcode and seed value.
interface xo256pp_cmd_if import xo256pp_pkg::*; ();
	logic    valid;
	logic    ready;
	opcode_t opcode;
	word_t   seed_value;

	modport source (output valid, opcode, seed_value, input ready);
	modport sink   (input valid, opcode, seed_value, output ready);
endinterface

[rtl/core/xo256pp_res_if.sv]
// Result channel: random value and state-nonzero flag.
interface xo256pp_res_if import xo256pp_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t random_value;
	logic  state_valid;

	modport source (output valid, random_value, state_valid, input ready);
	modport sink   (input valid, random_value, state_valid, output ready);
endinterface

[rtl/core/xo256pp_core.sv]
// Generator state, shared advance unit and jump accumulator.
module xo256pp_core import xo256pp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	input  word_t      seed_value,
	output core_stat_t stat
);

	word_t words_q [WORD_COUNT];
	word_t accum_q [WORD_COUNT];
	word_t adv     [WORD_COUNT];
	word_t t;
	word_t s2;
	word_t s3;
	word_t sum;

	// One xorshift/rotate update, reused by sample and by every jump step
	always_comb begin
		t      = words_q[1] << 17;
		s2     = words_q[2] ^ words_q[0];
		s3     = words_q[3] ^ words_q[1];
		adv[1] = words_q[1] ^ s2;
		adv[0] = words_q[0] ^ s3;
		adv[2] = s2 ^ t;
		adv[3] = {s3[WORD_W-46:0], s3[WORD_W-1:WORD_W-45]};
	end

	always_comb begin
		sum = words_q[0] + words_q[3];
		stat.sample_value = {sum[WORD_W-24:0], sum[WORD_W-1:WORD_W-23]} + words_q[0];
		stat.words_nz = |{words_q[0], words_q[1], words_q[2], words_q[3]};
		stat.accum_nz = |{accum_q[0], accum_q[1], accum_q[2], accum_q[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORD_COUNT; i++) begin
				words_q[i] <= '0;
				accum_q[i] <= '0;
			end
		end else begin
			unique case (ctrl.op)
				CORE_HOLD: ;
				CORE_SAMPLE: begin
					for (int i = 0; i < WORD_COUNT; i++) words_q[i] <= adv[i];
				end
				CORE_SEED: begin
					for (int i = 0; i < WORD_COUNT; i++) words_q[i] <= seed_value;
				end
				CORE_JSTART: begin
					for (int i = 0; i < WORD_COUNT; i++) accum_q[i] <= '0;
				end
				CORE_JSTEP: begin
					for (int i = 0; i < WORD_COUNT; i++) begin
						if (ctrl.poly_bit) accum_q[i] <= accum_q[i] ^ words_q[i];
						words_q[i] <= adv[i];
					end
				end
				CORE_JLOAD: begin
					for (int i = 0; i < WORD_COUNT; i++) words_q[i] <= accum_q[i];
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/xoshiro256pp_generator.sv]
// Xoshiro256++ generator top level: command sequencer and result register.
// A sample or a seed fill loads its word into the result register at the accepting
// edge. A new command is taken each cycle while the result register is empty or
// being drained. A short or long jump is the accept, 256 passes of the single
// advance unit (one update and one conditional accumulate per cycle), and a load
// of the accumulator back into the state. The load waits while the previous word
// is still held. No command is taken during a jump.
`include "xoshiro256pp_generator_macros.svh"

module xoshiro256pp_generator import xo256pp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	xo256pp_cmd_if.sink   cmd,
	xo256pp_res_if.source res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_JUMP,
		ST_LOAD
	} state_t;

	state_t              state_q;
	logic [COUNT_W-1:0]  jump_bit_count_q;
	logic                long_q;
	logic                res_valid_q;
	word_t               res_value_q;
	logic                res_nz_q;

	core_ctrl_t ctrl;
	core_stat_t stat;
	logic       out_free;
	logic       cmd_fire;
	logic       last_step;
	logic       is_jump;
	logic       res_load;

	assign out_free  = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign last_step = (jump_bit_count_q == COUNT_W'(WORD_W * WORD_COUNT - 1));
	assign is_jump   = (cmd.opcode == OP_SHORT_JMP) || (cmd.opcode == OP_LONG_JMP);
	assign res_load  = ((state_q == ST_IDLE) && cmd_fire && !is_jump) ||
		((state_q == ST_LOAD) && out_free);

	assign res.valid        = res_valid_q;
	assign res.random_value = res_value_q;
	assign res.state_valid  = res_nz_q;

	always_comb begin
		ctrl.op       = CORE_HOLD;
		ctrl.poly_bit = jump_poly_bit(long_q, jump_bit_count_q);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					unique case (cmd.opcode)
						OP_SAMPLE:    ctrl.op = CORE_SAMPLE;
						OP_SEED:      ctrl.op = CORE_SEED;
						OP_SHORT_JMP: ctrl.op = CORE_JSTART;
						OP_LONG_JMP:  ctrl.op = CORE_JSTART;
						default:      ctrl.op = CORE_HOLD;
					endcase
				end
			end
			ST_JUMP: ctrl.op = CORE_JSTEP;
			ST_LOAD: if (out_free) ctrl.op = CORE_JLOAD;
			default: ctrl.op = CORE_HOLD;
		endcase
	end

	xo256pp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.seed_value (cmd.seed_value),
		.stat       (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			jump_bit_count_q <= '0;
			long_q           <= 1'b0;
			res_valid_q      <= 1'b0;
			res_value_q      <= '0;
			res_nz_q         <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						priority if (cmd.opcode == OP_SAMPLE) begin
							res_value_q <= stat.sample_value;
							// advance is a bijection, so nonzero-ness carries over
							res_nz_q    <= stat.words_nz;
						end else if (cmd.opcode == OP_SEED) begin
							res_value_q <= '0;
							res_nz_q    <= |cmd.seed_value;
						end else begin
							long_q           <= (cmd.opcode == OP_LONG_JMP);
							jump_bit_count_q <= '0;
							state_q          <= ST_JUMP;
						end
					end
				end
				ST_JUMP: begin
					jump_bit_count_q <= jump_bit_count_q + 1'b1;
					if (last_step) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						res_value_q <= '0;
						res_nz_q    <= stat.accum_nz;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`XO_ASSERT_NOW(a_ready_only_idle, cmd.ready, state_q == ST_IDLE, "command taken while busy")
	`XO_ASSERT_NEXT(a_jump_starts, cmd_fire && is_jump, (state_q == ST_JUMP) && (jump_bit_count_q == '0), "jump did not start at bit zero")
	`XO_ASSERT_NEXT(a_jump_ends, (state_q == ST_JUMP) && last_step, state_q == ST_LOAD, "jump did not end after last bit")
	`XO_ASSERT_NEXT(a_quick_result, cmd_fire && !is_jump, res_valid_q && (state_q == ST_IDLE), "sample or seed gave no word")

endmodule

[sim/xoshiro256pp_generator_test.sv]
// Self-checking testbench for the xoshiro256++ generator: predicts each result word and compares.
module xoshiro256pp_generator_test;
	import xo256pp_pkg::*;

	localparam int          CYCLE_LIMIT = 2_000_000;
	localparam int          DRAIN_WAIT  = 300;
	localparam int          HOLD_AT     = 3000;
	localparam int          HOLD_LEN    = 600;
	localparam logic [255:0] SHORT_JUMP_POLY = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};
	localparam logic [255:0] LONG_JUMP_POLY = {
		64'h39109bb02acbe635, 64'h77710069854ee241,
		64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
	};

	typedef struct packed {
		word_t random_value;
		logic  state_valid;
	} gen_word_t;

	typedef struct {
		opcode_t op;
		word_t   seed;
		bit      drain;
	} cmd_item_t;

	logic clk;
	logic arst_n;

	xo256pp_cmd_if cmd ();
	xo256pp_res_if res ();

	xoshiro256pp_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	cmd_item_t   cmd_queue [$];
	gen_word_t   expected_words [$];
	word_t       gen_state [WORD_COUNT];

	int          mismatches;
	int          words_checked;
	int          cycle_count;
	int          n_sample, n_seed, n_short, n_long, n_zero_state;

	int          burst_left, gap_left;
	int          rx_cycles, hold_left, mode_left, rx_mode;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic word_t rot_word(word_t x, int unsigned k);
		return (x << k) | (x >> (WORD_W - k));
	endfunction

	function automatic void advance_state();
		word_t t;
		t = gen_state[1] << 17;
		gen_state[2] ^= gen_state[0];
		gen_state[3] ^= gen_state[1];
		gen_state[1] ^= gen_state[2];
		gen_state[0] ^= gen_state[3];
		gen_state[2] ^= t;
		gen_state[3] = rot_word(gen_state[3], 45);
	endfunction

	function automatic void poly_jump(logic [255:0] poly);
		word_t acc [WORD_COUNT];
		for (int j = 0; j < WORD_COUNT; j++)
			acc[j] = '0;
		for (int n = 0; n < 256; n++) begin
			if (poly[n]) begin
				for (int j = 0; j < WORD_COUNT; j++)
					acc[j] ^= gen_state[j];
			end
			advance_state();
		end
		for (int j = 0; j < WORD_COUNT; j++)
			gen_state[j] = acc[j];
	endfunction

	// Apply one command to the predicted state and return the word it should produce
	function automatic gen_word_t apply_command(opcode_t op, word_t seed);
		gen_word_t w;
		w.random_value = '0;
		case (op)
			OP_SAMPLE: begin
				w.random_value = rot_word(gen_state[0] + gen_state[3], 23) + gen_state[0];
				advance_state();
				n_sample++;
			end
			OP_SEED: begin
				for (int j = 0; j < WORD_COUNT; j++)
					gen_state[j] = seed;
				n_seed++;
			end
			OP_SHORT_JMP: begin
				poly_jump(SHORT_JUMP_POLY);
				n_short++;
			end
			default: begin
				poly_jump(LONG_JUMP_POLY);
				n_long++;
			end
		endcase
		w.state_valid = |(gen_state[0] | gen_state[1] | gen_state[2] | gen_state[3]);
		if (!w.state_valid)
			n_zero_state++;
		return w;
	endfunction

	function automatic word_t pick_seed();
		case ($urandom_range(15, 0))
			0:       return '0;
			1:       return '1;
			2:       return word_t'(1) << $urandom_range(63, 0);
			3:       return ~(word_t'(1) << $urandom_range(63, 0));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void add_cmd(opcode_t op, word_t seed);
		cmd_item_t it;
		it.op = op;
		it.seed = seed;
		it.drain = 1'b0;
		cmd_queue.push_back(it);
	endfunction

	function automatic void add_drain();
		cmd_item_t it;
		it.op = OP_SAMPLE;
		it.seed = '0;
		it.drain = 1'b1;
		cmd_queue.push_back(it);
	endfunction

	// Stimulus: directed corner cases, then seeded runs with random content and some noise
	initial begin
		int n_items;
		int run_len;
		int r;
		arst_n = 1'b0;
		n_items = 0;

		// unseeded state: everything stays zero
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SHORT_JMP, '0);
		add_cmd(OP_LONG_JMP, '0);
		add_cmd(OP_SEED, '0);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SHORT_JMP, '0);
		// all ones, single-bit and mixed seeds
		add_cmd(OP_SEED, '1);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SHORT_JMP, '1);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_LONG_JMP, '0);
		add_cmd(OP_SAMPLE, '1);
		add_cmd(OP_SEED, 64'd1);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SEED, 64'h8000_0000_0000_0000);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_LONG_JMP, '0);
		add_cmd(OP_SHORT_JMP, '0);
		add_cmd(OP_SAMPLE, '0);
		add_cmd(OP_SEED, 64'h0123_4567_89ab_cdef);
		add_cmd(OP_SAMPLE, '0);
		add_drain();
		n_items = 24;

		while (n_items < 1750) begin
			if ($urandom_range(9, 0) == 0) begin
				// noise: arbitrary commands, no seed first
				run_len = $urandom_range(6, 1);
				repeat (run_len) begin
					add_cmd(opcode_t'($urandom_range(3, 0)), {$urandom, $urandom});
					n_items++;
				end
			end else begin
				add_cmd(OP_SEED, pick_seed());
				n_items++;
				run_len = $urandom_range(40, 1);
				repeat (run_len) begin
					r = $urandom_range(99, 0);
					if (r < 92)
						add_cmd(OP_SAMPLE, {$urandom, $urandom});
					else if (r < 96)
						add_cmd(OP_SHORT_JMP, {$urandom, $urandom});
					else
						add_cmd(OP_LONG_JMP, {$urandom, $urandom});
					n_items++;
				end
			end
			if (n_items >= 600 && n_items < 650)
				add_drain();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (cmd_queue.size() != 0 || cmd.valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d samples, %0d seed fills, %0d short and %0d long jumps,",
			n_sample, n_seed, n_short, n_long);
		$display("%0d words checked, %0d with an all-zero state, %0d mismatches.",
			words_checked, n_zero_state, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Command driver: bursts with random gaps, honors drain markers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.opcode <= OP_SAMPLE;
			cmd.seed_value <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (cmd.valid && cmd.ready)
				expected_words.push_back(apply_command(cmd.opcode, cmd.seed_value));
			if (cmd.valid && !cmd.ready) begin
				// hold the word until it is taken
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				cmd.valid <= 1'b0;
			end else if (cmd_queue.size() == 0) begin
				cmd.valid <= 1'b0;
			end else if (cmd_queue[0].drain) begin
				// release only once nothing is outstanding and no word moves this edge
				if (expected_words.size() == 0 && !(res.valid && res.ready))
					void'(cmd_queue.pop_front());
				cmd.valid <= 1'b0;
			end else begin
				cmd.valid <= 1'b1;
				cmd.opcode <= cmd_queue[0].op;
				cmd.seed_value <= cmd_queue[0].seed;
				void'(cmd_queue.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(60, 1);
					gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Result ready: random stall modes, plus one long hold-off to back up the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			rx_cycles <= 0;
			hold_left <= 0;
			mode_left <= 0;
			rx_mode <= 0;
		end else begin
			rx_cycles <= rx_cycles + 1;
			if (rx_cycles == HOLD_AT) begin
				hold_left <= HOLD_LEN;
				res.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res.ready <= (hold_left == 1);
			end else begin
				if (mode_left == 0) begin
					rx_mode <= $urandom_range(2, 0);
					mode_left <= $urandom_range(160, 16);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (rx_mode)
					0:       res.ready <= 1'b1;
					1:       res.ready <= ($urandom_range(3, 0) != 0);
					default: res.ready <= ($urandom_range(1, 0) != 0);
				endcase
			end
		end
	end

	// Result monitor: compare each taken word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected word random_value=%h state_valid=%b",
						res.random_value, res.state_valid);
			end else begin
				words_checked++;
				if (res.random_value !== expected_words[0].random_value ||
					res.state_valid !== expected_words[0].state_valid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: word %0d: random_value exp %h got %h, state_valid exp %b got %b",
							words_checked, expected_words[0].random_value, res.random_value,
							expected_words[0].state_valid, res.state_valid);
				end
				void'(expected_words.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_words.size());
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
